FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled during the given reset.
`define ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error(msg);

// Assert a property on the local clk, disabled during rst.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

FILE: rtl/lld_pkg.sv
// ---------------------------------------------------------------------------
// lld_pkg
// Codes, field widths and controller/datapath interface types of the
// least-loaded worker dispatcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lld_pkg;

  localparam int FUNC_W = 3;
  localparam int CONN_W = 10;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 4;
  localparam int BUSY_W = 8;

  localparam logic [BUSY_W-1:0] BUSY_LIMIT = 8'd100;
  localparam logic [BUSY_W-1:0] BUSY_MAX   = 8'd255;

  // Event codes
  localparam logic [FUNC_W-1:0] FN_REGISTER = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RESULT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PONG     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNREG    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DISPATCH = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_PING     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DISC     = 3'd2;
  localparam logic [STAT_W-1:0] ST_DISP     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd6;

  typedef struct packed {
    logic load;    // latch a new event and rewind the slot walk
    logic walk;    // walk the slot table
    logic finish;  // emit the closing result of the event
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_stop;  // walk emitted the final result
    logic to_finish;  // walk is over, closing result still to emit
    logic out_free;   // output register can take a beat
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/least_loaded_worker_dispatcher_top.sv
// ---------------------------------------------------------------------------
// least_loaded_worker_dispatcher_top
// Worker slot table with register/result/pong/unregister lookups, heartbeat
// tick and least-loaded dispatch.
// ---------------------------------------------------------------------------
// One event is handled at a time. A register event goes straight to its
// closing result. Result, pong, unregister and dispatch walk the filled
// slots in order, one slot per cycle through the single read port of the slot
// memory while no beat waits for the output register. A walk that runs to the
// end reads each slot, drains the read stage and then emits the closing
// result. A lookup stops at its match, a dispatch at the first idle slot. A
// ping tick gives one beat per active slot and ends with the beat of the
// highest active slot; with no active slot its single beat closes it. The walk
// holds while a beat waits for the output register to empty. Undefined event
// codes are dropped. The slot memory needs no clearing pass; the block is
// ready right after reset. Result beats wait in an output register, so the
// next event is accepted while the last beat is still pending.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_worker_dispatcher_top #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] conn_id
  input  wire logic [2:0]  s_tuser,   // [2:0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [3:0] slot, [13:4] worker_conn
  output logic [2:0]       m_tuser,   // [2:0] status
  output logic             m_tlast
);
  import lld_pkg::*;

  ctrl_cmd_t           cmd;
  dp_stat_t            stat;
  logic [SLOT_W-1:0]   out_slot;
  logic [CONN_W-1:0]   out_conn;

  lld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  lld_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (s_tuser),
    .in_conn    (s_tdata[CONN_W-1:0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_slot   (out_slot),
    .out_conn   (out_conn),
    .out_last   (m_tlast)
  );

  assign m_tdata = {2'b00, out_conn, out_slot};

endmodule

`default_nettype wire

FILE: rtl/lld_ctrl.sv
// ---------------------------------------------------------------------------
// lld_ctrl
// Event sequencer: accepts an event, runs the slot walk where the event needs one, closes the event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lld_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [lld_pkg::FUNC_W-1:0] func,
  input  wire lld_pkg::dp_stat_t        stat,
  output lld_pkg::ctrl_cmd_t            cmd
);
  import lld_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign cmd.load   = accept;
  assign cmd.walk   = (state == S_WALK);
  assign cmd.finish = (state == S_FINISH);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (func == FN_REGISTER) begin
            state_next = S_FINISH;
          end else if (func >= FN_RESULT && func <= FN_DISPATCH) begin
            state_next = S_WALK;
          end else begin
            // undefined codes: drop silently
            state_next = S_IDLE;
          end
        end
      end
      S_WALK: begin
        priority if (stat.walk_stop) begin
          state_next = S_IDLE;
        end else if (stat.to_finish) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lld_dp.sv
// ---------------------------------------------------------------------------
// lld_dp
// Slot table, one-slot-per-cycle walk pipeline (held while a result beat stalls) and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lld_dp #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lld_pkg::ctrl_cmd_t         cmd,
  output lld_pkg::dp_stat_t               stat,
  input  wire logic [lld_pkg::FUNC_W-1:0] in_func,
  input  wire logic [lld_pkg::CONN_W-1:0] in_conn,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [lld_pkg::STAT_W-1:0]      out_status,
  output logic [lld_pkg::SLOT_W-1:0]      out_slot,
  output logic [lld_pkg::CONN_W-1:0]      out_conn,
  output logic                            out_last
);
  import lld_pkg::*;

  localparam int IW     = $clog2(NUM_SLOTS);
  localparam int CW     = $clog2(NUM_SLOTS + 1);
  localparam int WORD_W = BUSY_W + CONN_W;

  // slot memory: {busy, conn}
  logic [WORD_W-1:0]    mem [NUM_SLOTS];

  logic [FUNC_W-1:0]    func_q;
  logic [CONN_W-1:0]    conn_q;
  logic [CW-1:0]        used;
  logic [NUM_SLOTS-1:0] act;
  logic [NUM_SLOTS-1:0] ping;

  logic [CW-1:0]        idx;
  logic                 p_valid;
  logic [IW-1:0]        p_idx;
  logic [WORD_W-1:0]    p_word;

  logic [BUSY_W-1:0]    best;
  logic [IW-1:0]        pick;
  logic [WORD_W-1:0]    pick_word;
  logic                 found;

  logic [BUSY_W-1:0]    p_busy;
  logic [CONN_W-1:0]    p_conn;
  logic [BUSY_W-1:0]    pick_busy;
  logic                 out_free;
  logic                 p_act;
  logic                 is_lookup;
  logic                 is_tick;
  logic                 is_disp;
  logic                 hit;
  logic                 tick_hit;
  logic                 emit_req;
  logic                 stall;
  logic                 walk_emit;
  logic                 fin_emit;
  logic                 tail_clear;
  logic                 exhausted;
  logic                 zero_hit;
  logic                 issue;
  logic                 full;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [WORD_W-1:0]    wr_data;

  logic [STAT_W-1:0]    o_status;
  logic [IW-1:0]        o_slot;
  logic [CONN_W-1:0]    o_conn;
  logic                 o_last;

  assign p_busy    = p_word[WORD_W-1:CONN_W];
  assign p_conn    = p_word[CONN_W-1:0];
  assign pick_busy = pick_word[WORD_W-1:CONN_W];

  assign out_free  = !out_valid || out_ready;
  assign p_act     = p_valid && act[p_idx];
  assign is_lookup = (func_q == FN_RESULT) || (func_q == FN_PONG) || (func_q == FN_UNREG);
  assign is_tick   = (func_q == FN_TICK);
  assign is_disp   = (func_q == FN_DISPATCH);
  assign full      = (used == CW'(NUM_SLOTS));

  assign hit        = is_lookup && p_act && (p_conn == conn_q);
  assign tick_hit   = is_tick && p_act;
  assign emit_req   = cmd.walk && (hit || tick_hit);
  assign stall      = emit_req && !out_free;
  assign walk_emit  = emit_req && out_free;
  assign fin_emit   = cmd.finish && out_free;
  // no active slot above the one in the stage: this tick result closes the event
  assign tail_clear = !(|((act >> 1) >> p_idx));
  assign exhausted  = (idx == used) && !p_valid;
  assign zero_hit   = cmd.walk && is_disp && p_act && (p_busy == '0);
  assign issue      = cmd.walk && !stall && (idx < used);

  assign stat.walk_stop = walk_emit && (hit || tail_clear);
  assign stat.to_finish = cmd.walk && (is_tick ? !(|act) : (exhausted || zero_hit));
  assign stat.out_free  = out_free;

  // result fields
  always_comb begin
    o_status = ST_NONE;
    o_slot   = '0;
    o_conn   = '0;
    o_last   = 1'b1;
    if (cmd.walk) begin
      if (hit) begin
        o_status = ST_DONE;
        o_slot   = p_idx;
        o_conn   = p_conn;
      end else begin
        o_status = ping[p_idx] ? ST_DISC : ST_PING;
        o_slot   = p_idx;
        o_conn   = p_conn;
        o_last   = tail_clear;
      end
    end else begin
      priority if (func_q == FN_REGISTER) begin
        o_conn = conn_q;
        if (full) begin
          o_status = ST_FULL;
        end else begin
          o_status = ST_DONE;
          o_slot   = used[IW-1:0];
        end
      end else if (is_lookup) begin
        o_status = ST_NOTFOUND;
        o_conn   = conn_q;
      end else if (is_disp && found) begin
        o_status = ST_DISP;
        o_slot   = pick;
        o_conn   = pick_word[CONN_W-1:0];
      end else begin
        o_status = ST_NONE;
      end
    end
  end

  // slot memory write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx;
    wr_data = {(p_busy == '0) ? p_busy : p_busy - 1'b1, p_conn};
    priority if (walk_emit && hit && func_q == FN_RESULT) begin
      wr_en = 1'b1;
    end else if (fin_emit && func_q == FN_REGISTER && !full) begin
      wr_en   = 1'b1;
      wr_addr = used[IW-1:0];
      wr_data = {{BUSY_W{1'b0}}, conn_q};
    end else if (fin_emit && is_disp && found) begin
      wr_en   = 1'b1;
      wr_addr = pick;
      wr_data = {(pick_busy == BUSY_MAX) ? pick_busy : pick_busy + 1'b1,
                 pick_word[CONN_W-1:0]};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) p_word <= mem[idx[IW-1:0]];
  end

  // event latch, walk pipeline, dispatch tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      p_valid <= 1'b0;
      found   <= 1'b0;
    end else if (cmd.load) begin
      idx     <= '0;
      p_valid <= 1'b0;
      found   <= 1'b0;
    end else begin
      if (cmd.walk && !stall) begin
        p_valid <= issue;
        idx     <= idx + CW'(issue);
      end
      if (cmd.walk && is_disp && p_act && p_busy < best) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      conn_q <= in_conn;
      best   <= BUSY_LIMIT;
    end else if (cmd.walk && is_disp && p_act && p_busy < best) begin
      best      <= p_busy;
      pick      <= p_idx;
      pick_word <= p_word;
    end
    if (cmd.walk && !stall) p_idx <= idx[IW-1:0];
  end

  // slot flags and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      act  <= '0;
      ping <= '0;
    end else if (walk_emit) begin
      if (hit) begin
        if (func_q == FN_PONG) ping[p_idx] <= 1'b0;
        if (func_q == FN_UNREG) act[p_idx] <= 1'b0;
      end else if (ping[p_idx]) begin
        act[p_idx] <= 1'b0;
      end else begin
        ping[p_idx] <= 1'b1;
      end
    end else if (fin_emit && func_q == FN_REGISTER && !full) begin
      act[used[IW-1:0]]  <= 1'b1;
      ping[used[IW-1:0]] <= 1'b0;
      used               <= used + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (walk_emit || fin_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_emit || fin_emit) begin
      out_status <= o_status;
      out_slot   <= SLOT_W'(o_slot);
      out_conn   <= o_conn;
      out_last   <= o_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lld_checker.sv
// ---------------------------------------------------------------------------
// lld_checker
// Port-level checks of the dispatcher, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lld_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [2:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);
  import lld_pkg::*;

  logic        in_event;
  logic        out_stall;
  logic        multi_stat;
  logic        fail_stat;
  logic        none_stat;
  logic [3:0]  out_slot;
  logic [9:0]  out_conn;
  logic [20:0] out_beat;

  assign in_event   = s_tvalid && s_tready && (s_tuser <= FN_DISPATCH);
  assign out_stall  = m_tvalid && !m_tready;
  assign multi_stat = (m_tuser == ST_PING) || (m_tuser == ST_DISC);
  assign fail_stat  = (m_tuser == ST_FULL) || (m_tuser == ST_NOTFOUND) || (m_tuser == ST_NONE);
  assign none_stat  = (m_tuser == ST_NONE);
  assign out_slot   = m_tdata[3:0];
  assign out_conn   = m_tdata[13:4];
  assign out_beat   = {m_tvalid, m_tlast, m_tuser, m_tdata};

  // a stalled result beat holds
  `ASSERT_STD(a_out_hold, out_stall |=> $stable(out_beat), "result beat changed while stalled")

  // only tick results can be followed by more beats of the same event
  `ASSERT_STD(a_single_last, m_tvalid && !multi_stat |-> m_tlast, "single result without last")

  // a defined event blocks the input until it is handled
  `ASSERT_STD(a_busy_after_accept, in_event |=> !s_tready, "input ready right after an event")

  // failures report slot zero
  `ASSERT_STD(a_fail_slot, m_tvalid && fail_stat |-> out_slot == '0, "failure with nonzero slot")

  // no-worker results carry no connection id
  `ASSERT_STD(a_none_conn, m_tvalid && none_stat |-> out_conn == '0, "no-worker result with conn id")

endmodule

bind least_loaded_worker_dispatcher_top lld_checker u_lld_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the least-loaded worker dispatcher. A local copy
// of the worker table predicts every result beat per event; a monitor
// compares each beat taken on the master side with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lld_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 150;

  // Event codes the block ignores
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [CONN_W-1:0] conn;
    logic              last;
  } beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [9:0] conn_id
  logic [2:0]  s_tuser;   // [2:0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [3:0] slot, [13:4] worker_conn
  logic [2:0]  m_tuser;   // [2:0] status
  logic        m_tlast;

  // Local copy of the worker table
  logic [CONN_W-1:0] tbl_conn   [NUM_SLOTS];
  logic              tbl_active [NUM_SLOTS];
  logic [BUSY_W-1:0] tbl_busy   [NUM_SLOTS];
  logic              tbl_ping   [NUM_SLOTS];
  int                tbl_used;

  beat_t beats_due[$];

  logic [FUNC_W-1:0] lookup_fns[3] = '{FN_RESULT, FN_PONG, FN_UNREG};

  int  fail_count   = 0;
  int  events_sent  = 0;
  int  beats_seen   = 0;
  int  stat_seen[8] = '{default: 0};
  int  stall_cnt    = 0;
  int  sink_hold    = 0;
  int  sink_gap     = 0;
  bit  idle_on      = 1'b1;

  least_loaded_worker_dispatcher_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic beat_t mk_beat(input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] sl,
                                    input logic [CONN_W-1:0] cid);
    beat_t b;
    b.status = st;
    b.slot   = sl;
    b.conn   = cid;
    b.last   = 1'b0;
    return b;
  endfunction

  // Apply one event to the local table and queue the beats it causes.
  task automatic table_update(input logic [FUNC_W-1:0] fn, input logic [CONN_W-1:0] cid);
    beat_t             out[$];
    int                hit;
    int                pick;
    int                i;
    bit                idle_found;
    logic [BUSY_W-1:0] least;
    hit        = -1;
    pick       = -1;
    idle_found = 1'b0;
    least      = BUSY_LIMIT;
    case (fn)
      FN_REGISTER: begin
        if (tbl_used >= NUM_SLOTS) begin
          out.push_back(mk_beat(ST_FULL, '0, cid));
        end else begin
          tbl_conn[tbl_used]   = cid;
          tbl_active[tbl_used] = 1'b1;
          tbl_busy[tbl_used]   = '0;
          tbl_ping[tbl_used]   = 1'b0;
          out.push_back(mk_beat(ST_DONE, SLOT_W'(tbl_used), cid));
          tbl_used++;
        end
      end
      FN_RESULT, FN_PONG, FN_UNREG: begin
        // lowest active slot with a matching id wins
        for (i = 0; i < tbl_used && hit < 0; i++)
          if (tbl_active[i] && tbl_conn[i] == cid) hit = i;
        if (hit < 0) begin
          out.push_back(mk_beat(ST_NOTFOUND, '0, cid));
        end else begin
          if (fn == FN_RESULT) begin
            if (tbl_busy[hit] != '0) tbl_busy[hit]--;
          end else if (fn == FN_PONG) begin
            tbl_ping[hit] = 1'b0;
          end else begin
            tbl_active[hit] = 1'b0;
          end
          out.push_back(mk_beat(ST_DONE, SLOT_W'(hit), tbl_conn[hit]));
        end
      end
      FN_TICK: begin
        for (i = 0; i < tbl_used; i++) begin
          if (tbl_active[i]) begin
            if (tbl_ping[i]) begin
              tbl_active[i] = 1'b0;
              out.push_back(mk_beat(ST_DISC, SLOT_W'(i), tbl_conn[i]));
            end else begin
              tbl_ping[i] = 1'b1;
              out.push_back(mk_beat(ST_PING, SLOT_W'(i), tbl_conn[i]));
            end
          end
        end
        if (out.size() == 0) out.push_back(mk_beat(ST_NONE, '0, '0));
      end
      FN_DISPATCH: begin
        for (i = 0; i < tbl_used && !idle_found; i++) begin
          if (tbl_active[i]) begin
            if (tbl_busy[i] == '0) begin
              pick       = i;
              idle_found = 1'b1;
            end else if (tbl_busy[i] < least) begin
              least = tbl_busy[i];
              pick  = i;
            end
          end
        end
        if (pick < 0) begin
          out.push_back(mk_beat(ST_NONE, '0, '0));
        end else begin
          if (tbl_busy[pick] != BUSY_MAX) tbl_busy[pick]++;
          out.push_back(mk_beat(ST_DISP, SLOT_W'(pick), tbl_conn[pick]));
        end
      end
      default: ;
    endcase
    if (out.size() > 0) out[out.size()-1].last = 1'b1;
    foreach (out[j]) beats_due.push_back(out[j]);
  endtask

  // Offer one event beat, optionally after a short gap, and predict on accept.
  task automatic send_event(input logic [FUNC_W-1:0] fn, input logic [CONN_W-1:0] cid);
    int gap;
    gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {6'b0, cid};
    do @(posedge clk); while (!s_tready);
    table_update(fn, cid);
    events_sent++;
  endtask

  // Stop offering and wait until every predicted beat has been seen.
  task automatic drain_beats();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_event(FN_TICK, 10'h000);        // empty table
    send_event(FN_DISPATCH, 10'h3FF);    // nobody to take the job
    send_event(FN_RESULT, 10'h000);      // unknown workers
    send_event(FN_PONG, 10'h3FF);
    send_event(FN_UNREG, 10'h155);
    send_event(FN_REGISTER, 10'h3FF);
    send_event(FN_REGISTER, 10'h000);
    send_event(FN_REGISTER, 10'h3FF);    // duplicate id gets a new slot
    send_event(FN_DISPATCH, 10'h000);
    send_event(FN_DISPATCH, 10'h000);
    send_event(FN_DISPATCH, 10'h000);
    send_event(FN_DISPATCH, 10'h2AA);    // three-way tie
    send_event(FN_RESULT, 10'h3FF);
    send_event(FN_RESULT, 10'h000);
    send_event(FN_RESULT, 10'h000);      // busy already zero
    send_event(FN_PONG, 10'h000);        // no ping outstanding
    send_event(FN_TICK, 10'h3FF);
    send_event(FN_PONG, 10'h000);
    send_event(FN_TICK, 10'h000);        // silent slots drop out
    send_event(FN_UNREG, 10'h3FF);
    send_event(FN_SPARE_LO, 10'h2AA);
    send_event(FN_SPARE_HI, 10'h155);
    send_event(FN_DISPATCH, 10'h000);
    send_event(FN_PONG, 10'h000);
  endtask

  task automatic test_random_traffic(input int n_items);
    int                sent;
    int                r;
    int                i;
    int                live[$];
    logic [CONN_W-1:0] cid;
    bit                hold_done;
    bit                drain_done;
    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    while (sent < n_items) begin
      live.delete();
      for (i = 0; i < tbl_used; i++) if (tbl_active[i]) live.push_back(i);
      if (live.size() > 0) cid = tbl_conn[live[$urandom_range(live.size() - 1)]];
      else cid = CONN_W'($urandom_range(1023));
      if (!hold_done && sent >= 100) begin
        sink_hold = LONG_HOLD;   // fill the block while sink is blocked
        hold_done = 1'b1;
      end
      if (!drain_done && sent >= 200) begin
        drain_beats();
        drain_done = 1'b1;
      end
      r = $urandom_range(99);
      // keep one slot in reserve for the ceiling test
      if ((r < 5 || live.size() == 0) && tbl_used < NUM_SLOTS - 1) begin
        if (live.size() == 0 || $urandom_range(9) != 0) cid = CONN_W'($urandom_range(1023));
        send_event(FN_REGISTER, cid);
        sent++;
      end else if (live.size() == 0 || r >= 90) begin
        case ($urandom_range(3))
          0: send_event($urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO,
                        CONN_W'($urandom_range(1023)));
          1: begin
            send_event(FN_TICK, CONN_W'($urandom_range(1023)));
            sent++;
          end
          default: begin
            send_event(lookup_fns[$urandom_range(2)], CONN_W'($urandom_range(1023)));
            sent++;
          end
        endcase
      end else if (r < 35) begin
        send_event(FN_DISPATCH, CONN_W'($urandom_range(1023)));
        sent++;
      end else if (r < 52) begin
        send_event(FN_RESULT, cid);
        sent++;
      end else if (r < 64) begin
        send_event(FN_PONG, cid);
        sent++;
      end else if (r < 68) begin
        send_event(live.size() > 2 ? FN_UNREG : FN_PONG, cid);
        sent++;
      end else if (r < 80) begin
        // mostly answer outstanding pings so workers survive the tick
        if ($urandom_range(9) < 7) begin
          foreach (live[j]) begin
            if (tbl_active[live[j]] && tbl_ping[live[j]]) begin
              send_event(FN_PONG, tbl_conn[live[j]]);
              sent++;
            end
          end
        end
        send_event(FN_TICK, CONN_W'($urandom_range(1023)));
        sent++;
      end else begin
        if (r < 82) drain_beats();
        send_event(FN_DISPATCH, CONN_W'($urandom_range(1023)));
        sent++;
      end
    end
  endtask

  // One lone worker taken to the busy limit, then a full table.
  task automatic test_busy_ceiling();
    int                i;
    logic [CONN_W-1:0] cid;
    idle_on = 1'b0;
    drain_beats();
    for (i = 0; i < tbl_used; i++)
      if (tbl_active[i]) send_event(FN_UNREG, tbl_conn[i]);
    cid = CONN_W'($urandom_range(1023));
    if (tbl_used < NUM_SLOTS) send_event(FN_REGISTER, cid);
    send_event(FN_TICK, 10'h000);
    repeat (101) send_event(FN_DISPATCH, CONN_W'($urandom_range(1023)));
    send_event(FN_PONG, cid);
    send_event(FN_RESULT, cid);
    send_event(FN_DISPATCH, 10'h000);
    send_event(FN_DISPATCH, 10'h000);
    send_event(FN_TICK, 10'h000);
    send_event(FN_TICK, 10'h000);
    send_event(FN_TICK, 10'h000);
    while (tbl_used < NUM_SLOTS) send_event(FN_REGISTER, CONN_W'($urandom_range(1023)));
    send_event(FN_REGISTER, 10'h3FF);
    send_event(FN_REGISTER, 10'h000);
  endtask

  // Sink side: random ready bursts plus an occasional long hold.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else if (sink_gap > 0) begin
        m_tready <= 1'b0;
        sink_gap--;
      end else if (idle_on && $urandom_range(4) == 0) begin
        m_tready <= 1'b0;
        sink_gap = $urandom_range(2);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_beat
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      stat_seen[m_tuser]++;
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat status=%0d slot=%0d conn=%0h last=%0b", $time,
                 m_tuser, m_tdata[3:0], m_tdata[13:4], m_tlast);
        fail_count++;
      end else begin
        want = beats_due.pop_front();
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[3:0] !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, m_tdata[3:0]);
          fail_count++;
        end
        if (m_tdata[13:4] !== want.conn) begin
          $display("%0t: worker_conn expected %0h actual %0h", $time, want.conn,
                   m_tdata[13:4]);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    tbl_used = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_conn[i]   = '0;
      tbl_active[i] = 1'b0;
      tbl_busy[i]   = '0;
      tbl_ping[i]   = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(290);
    test_busy_ceiling();

    drain_beats();
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);

    $display("Covered %0d events and %0d result beats: %0d pings, %0d disconnects,",
             events_sent, beats_seen, stat_seen[ST_PING], stat_seen[ST_DISC]);
    $display("  %0d dispatches, %0d no-worker, %0d table-full, %0d unknown-worker replies",
             stat_seen[ST_DISP], stat_seen[ST_NONE], stat_seen[ST_FULL],
             stat_seen[ST_NOTFOUND]);
    if (fail_count == 0 && beats_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
